// File: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/dfa_pkg.sv
// Package: constants, opcodes and the table entry type of the DFA recognizer
`timescale 1ns / 1ps

package dfa_pkg;

    // Table geometry
    localparam int MAX_STATES = 16;
    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int CNT_W      = $clog2(MAX_STATES + 1);

    // Opcodes of an input beat
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_SYM   = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    // Character codes
    localparam logic [7:0] KIND_INITIAL = 8'h3E; // '>'
    localparam logic [7:0] KIND_ACCEPT  = 8'h2B; // '+'
    localparam logic [7:0] SYM_ZERO     = 8'h30; // '0'
    localparam logic [7:0] SYM_ONE      = 8'h31; // '1'
    localparam logic [7:0] SYM_EMPTY    = 8'h45; // 'E'

    // One table entry as stored in the memory
    typedef struct packed {
        logic [7:0] kind;
        logic [7:0] name;
        logic [7:0] next_zero;
        logic [7:0] next_one;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: src/dfa_table_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps

module dfa_table_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/binary_dfa_recognizer_core.sv
// Top level: table-driven binary DFA recognizer with a sequenced table search
`timescale 1ns / 1ps
// Table write, and a symbol that needs no lookup: handled in IDLE, the next beat may follow at once.
// Begin and other symbol beats: a table search over n = min(num_states, 16) entries; the search
// reads one table entry per cycle from the entry memory's read port, stopping at a hit.
// End beat: after the search the result waits in HOLD and is registered once the output register
// has room; input is free again on that load. Reset clears control state, num_states and
// the current name; the table memory is not cleared and must be written before use.

module binary_dfa_recognizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [3:0] i_entry_index,
    input  logic [7:0] i_entry_kind,
    input  logic [7:0] i_entry_name,
    input  logic [7:0] i_entry_next_zero,
    input  logic [7:0] i_entry_next_one,
    input  logic [7:0] i_symbol,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_accepted,
    output logic       o_final_found,
    output logic [7:0] o_final_name,
    output logic       o_empty_string
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } t_state;

    t_state r_state;

    // control and string state
    logic [4:0]                r_num;
    logic [1:0]                r_op;
    logic [7:0]                r_sym;
    logic [dfa_pkg::CNT_W-1:0] r_issue;
    logic                      r_rd_pend;
    logic [7:0]                r_cur;
    logic                      r_stuck;
    logic                      r_seen;
    logic                      r_empty;
    logic                      r_res_acc;
    logic                      r_res_found;

    // output register
    logic       r_out_valid;
    logic       r_accepted;
    logic       r_final_found;
    logic [7:0] r_final_name;
    logic       r_empty_string;

    logic                      w_in_acc;
    logic                      w_wr_en;
    logic                      w_issue;
    logic                      w_match;
    logic                      w_miss;
    logic                      w_out_free;
    logic [dfa_pkg::CNT_W-1:0] w_n_eff;
    logic [dfa_pkg::ENTRY_W-1:0] w_rd_raw;
    dfa_pkg::t_entry           w_rd;
    dfa_pkg::t_entry           w_wr;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // entries in use, clamped to the table depth
    always_comb begin
        if (32'(r_num) > dfa_pkg::MAX_STATES) begin
            w_n_eff = dfa_pkg::CNT_W'(dfa_pkg::MAX_STATES);
        end else begin
            w_n_eff = dfa_pkg::CNT_W'(r_num);
        end
    end

    // table write straight from an accepted write beat
    assign w_wr_en = w_in_acc && (i_opcode == dfa_pkg::OP_WRITE)
                     && (32'(i_entry_index) < dfa_pkg::MAX_STATES);
    assign w_wr.kind      = i_entry_kind;
    assign w_wr.name      = i_entry_name;
    assign w_wr.next_zero = i_entry_next_zero;
    assign w_wr.next_one  = i_entry_next_one;

    // search: issue one read per cycle, compare the entry read last cycle
    assign w_issue = (r_state == S_SEARCH) && (r_issue < w_n_eff);
    assign w_rd    = dfa_pkg::t_entry'(w_rd_raw);

    always_comb begin
        if (r_op == dfa_pkg::OP_BEGIN) begin
            w_match = r_rd_pend && ((w_rd.kind == dfa_pkg::KIND_INITIAL)
                                    || (w_rd.kind == dfa_pkg::KIND_ACCEPT));
        end else begin
            w_match = r_rd_pend && (w_rd.name == r_cur);
        end
    end

    assign w_miss = !w_match && (r_issue >= w_n_eff);

    dfa_table_ram #(
        .DATA_W (dfa_pkg::ENTRY_W),
        .DEPTH  (dfa_pkg::MAX_STATES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (dfa_pkg::IDX_W'(i_entry_index)),
        .i_wr_data (w_wr),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_issue[dfa_pkg::IDX_W-1:0]),
        .o_rd_data (w_rd_raw)
    );

    // sequencer, string state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            r_cur       <= '0;
            r_stuck     <= 1'b0;
            r_seen      <= 1'b0;
            r_empty     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_issue     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num <= i_cfg_data;
            end

            // beat taken by the sink; in HOLD the register is reloaded instead
            if (r_out_valid && i_out_ready && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op      <= i_opcode;
                        r_sym     <= i_symbol;
                        r_issue   <= '0;
                        r_rd_pend <= 1'b0;
                        unique case (i_opcode)
                            dfa_pkg::OP_WRITE: begin
                                r_state <= S_IDLE;
                            end
                            dfa_pkg::OP_BEGIN: begin
                                r_state <= S_SEARCH;
                            end
                            dfa_pkg::OP_SYM: begin
                                // empty-string and stuck cases need no search
                                priority if (r_empty) begin
                                    r_state <= S_IDLE;
                                end else if (!r_seen && i_symbol == dfa_pkg::SYM_EMPTY) begin
                                    r_seen  <= 1'b1;
                                    r_empty <= 1'b1;
                                    r_state <= S_IDLE;
                                end else if (r_stuck) begin
                                    r_seen  <= 1'b1;
                                    r_state <= S_IDLE;
                                end else begin
                                    r_seen  <= 1'b1;
                                    r_state <= S_SEARCH;
                                end
                            end
                            dfa_pkg::OP_END: begin
                                r_state <= S_SEARCH;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_SEARCH: begin
                    r_rd_pend <= w_issue;
                    if (w_issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (w_match || w_miss) begin
                        unique case (r_op)
                            dfa_pkg::OP_BEGIN: begin
                                r_cur   <= w_match ? w_rd.name : 8'h00;
                                r_stuck <= 1'b0;
                                r_seen  <= 1'b0;
                                r_empty <= 1'b0;
                                r_state <= S_IDLE;
                            end
                            dfa_pkg::OP_SYM: begin
                                r_state <= S_IDLE;
                                if (w_miss) begin
                                    r_stuck <= 1'b1;
                                end else if (r_sym == dfa_pkg::SYM_ZERO) begin
                                    r_cur <= w_rd.next_zero;
                                end else if (r_sym == dfa_pkg::SYM_ONE) begin
                                    r_cur <= w_rd.next_one;
                                end
                            end
                            dfa_pkg::OP_END: begin
                                r_res_found <= w_match;
                                r_res_acc   <= w_match && (w_rd.kind == dfa_pkg::KIND_ACCEPT);
                                r_state     <= S_HOLD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_HOLD: begin
                    // wait for room in the output register
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_accepted     <= r_res_acc;
                        r_final_found  <= r_res_found;
                        r_final_name   <= r_cur;
                        r_empty_string <= r_empty;
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_final_found  = r_final_found;
    assign o_final_name   = r_final_name;
    assign o_empty_string = r_empty_string;

endmodule

// File: src/dfa_checker.sv
// Port-level checker for the DFA recognizer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_opcode,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_accepted,
    input logic       o_final_found,
    input logic [7:0] o_final_name
);

    logic w_search_beat;

    // begin and end beats always go through a table search
    assign w_search_beat = i_in_valid && o_in_ready
                           && (i_opcode == dfa_pkg::OP_BEGIN || i_opcode == dfa_pkg::OP_END);

    // a result beat stays offered until taken
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a stalled result keeps its name
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_final_name))

    // acceptance needs the final state to be in the table
    `ASSERT_IMPL(a_acc_found, i_clk, i_rst_n, o_out_valid, !o_accepted || o_final_found)

    // a begin or end beat starts a search and drops ready
    `ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, w_search_beat, !o_in_ready)

    // a new result comes only out of a busy cycle
    `ASSERT_IMPL(a_res_src, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready))

endmodule

bind binary_dfa_recognizer_core dfa_checker u_dfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_accepted    (o_accepted),
    .o_final_found (o_final_found),
    .o_final_name  (o_final_name)
);
